// ----- rtl/u8s_pkg.sv -----
// shared types, constants and lead-byte decode for the utf-8 sanitizer
package u8s_pkg;

  localparam logic [7:0] SUBST_CHAR = 8'h3F;
  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] LEAD2_MIN  = 8'hC2;
  localparam logic [7:0] LEAD4_MAX  = 8'hF4;
  localparam logic [7:0] LEAD_E0    = 8'hE0;
  localparam logic [7:0] LEAD_ED    = 8'hED;
  localparam logic [7:0] LEAD_F0    = 8'hF0;
  localparam logic [7:0] CONT_A0    = 8'hA0;
  localparam logic [7:0] CONT_90    = 8'h90;
  localparam logic [7:0] CONT_8F    = 8'h8F;
  localparam logic [7:0] MASK_C0    = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;

  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);
  localparam int MAX_RES  = 4;

  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [MAX_RES-1:0]      rep;
    logic [2:0]              num;
    logic [2:0][7:0]         hold_bytes;
    logic [1:0]              hold_cnt;
  } scan_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       was_replaced;
    logic       run_last;
  } res_t;

  // 0 means the byte cannot start a sequence
  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] len;
    len = 3'd0;
    if (c <= ASCII_MAX) begin
      len = 3'd1;
    end else if (c[7:5] == 3'b110) begin
      len = (c < LEAD2_MIN) ? 3'd0 : 3'd2;
    end else if (c[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (c[7:3] == 5'b11110) begin
      len = (c > LEAD4_MAX) ? 3'd0 : 3'd4;
    end
    return len;
  endfunction

endpackage

// ----- rtl/u8s_if.sv -----
// valid/ready channels for input bytes and sanitized result words
interface u8s_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;
  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface u8s_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       was_replaced;
  logic       run_last;
  modport source (output valid, output out_byte, output was_replaced, output run_last,
                  input ready);
  modport sink (input valid, input out_byte, input was_replaced, input run_last,
                output ready);
endinterface

// ----- rtl/u8s_scan.sv -----
// single-pass scan of held bytes plus one new byte into results and new held state
module u8s_scan (
  input  logic [1:0]      pend_cnt,
  input  logic [2:0][7:0] pend_bytes,
  input  logic [7:0]      in_byte,
  input  logic            end_flag,
  output u8s_pkg::scan_t  scan
);
  import u8s_pkg::*;

  logic [3:0][7:0] q;
  logic [2:0]      n;
  logic [2:0]      i;
  logic [2:0]      k;
  logic            stop;
  logic [7:0]      lead;
  logic [7:0]      c1;
  logic [2:0]      len;
  logic [2:0]      avail;
  logic [2:0]      idx;
  logic            ok;

  always_comb begin
    q = '0;
    scan = '0;
    for (int j = 0; j < 3; j++) begin
      if (2'(j) < pend_cnt) begin
        q[j] = pend_bytes[j];
      end
    end
    q[pend_cnt] = in_byte;
    n = {1'b0, pend_cnt} + 3'd1;
    i = 3'd0;
    k = 3'd0;
    stop = 1'b0;
    lead = '0;
    c1 = '0;
    len = '0;
    avail = '0;
    idx = '0;
    ok = 1'b0;
    for (int it = 0; it < MAX_RES; it++) begin
      if (!stop && i < n) begin
        lead = q[i[1:0]];
        len = lead_len(lead);
        avail = n - i;
        if (avail > len) begin
          avail = len;
        end
        ok = 1'b1;
        for (int j = 1; j < MAX_RES; j++) begin
          idx = i + 3'(j);
          if (3'(j) < avail && (q[idx[1:0]] & MASK_C0) != CONT_TAG) begin
            ok = 1'b0;
          end
        end
        idx = i + 3'd1;
        c1 = q[idx[1:0]];
        if (avail >= 3'd2) begin
          if (len == 3'd3 && ((lead == LEAD_E0 && c1 < CONT_A0) ||
                              (lead == LEAD_ED && c1 >= CONT_A0))) begin
            ok = 1'b0;
          end
          if (len == 3'd4 && ((lead == LEAD_F0 && c1 < CONT_90) ||
                              (lead == LEAD4_MAX && c1 > CONT_8F))) begin
            ok = 1'b0;
          end
        end
        if (len == 3'd0 || !ok) begin
          scan.bytes[k[1:0]] = SUBST_CHAR;
          scan.rep[k[1:0]] = 1'b1;
          k = k + 3'd1;
          i = i + 3'd1;
        end else if (avail == len) begin
          for (int j = 0; j < MAX_RES; j++) begin
            if (3'(j) < len) begin
              idx = i + 3'(j);
              scan.bytes[k[1:0]] = q[idx[1:0]];
              scan.rep[k[1:0]] = 1'b0;
              k = k + 3'd1;
            end
          end
          i = i + len;
        end else if (end_flag) begin
          scan.bytes[k[1:0]] = SUBST_CHAR;
          scan.rep[k[1:0]] = 1'b1;
          k = k + 3'd1;
          i = i + 3'd1;
        end else begin
          // incomplete sequence: keep the rest for the next word
          for (int j = 0; j < 3; j++) begin
            idx = i + 3'(j);
            if (3'(j) < n - i) begin
              scan.hold_bytes[j] = q[idx[1:0]];
            end
          end
          idx = n - i;
          scan.hold_cnt = idx[1:0];
          stop = 1'b1;
        end
      end
    end
    scan.num = k;
  end

endmodule

// ----- rtl/u8s_outq.sv -----
// result queue taking up to four words per cycle and draining one per cycle while result.ready is high
module u8s_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  u8s_pkg::scan_t        scan,
  output logic [u8s_pkg::OQ_CW-1:0] level,
  u8s_result_if.source          result
);
  import u8s_pkg::*;

  res_t             mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr;
  logic [OQ_AW-1:0] rd_ptr;
  logic [OQ_CW-1:0] level_next;
  logic [2:0]       push_num;
  logic             pop;

  assign push_num = push ? scan.num : 3'd0;
  assign pop = result.valid && result.ready;
  assign level_next = level + OQ_CW'(push_num) - OQ_CW'(pop);

  assign result.valid        = level != '0;
  assign result.out_byte     = mem[rd_ptr].out_byte;
  assign result.was_replaced = mem[rd_ptr].was_replaced;
  assign result.run_last     = mem[rd_ptr].run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_AW'(push_num);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int m = 0; m < MAX_RES; m++) begin
      if (3'(m) < push_num) begin
        mem[wr_ptr + OQ_AW'(m)] <= '{out_byte: scan.bytes[m], was_replaced: scan.rep[m],
                                     run_last: (3'(m) == push_num - 3'd1)};
      end
    end
  end

endmodule

// ----- rtl/utf8_lossy_sanitizer_unit.sv -----
// top level of the utf-8 lossy sanitizer: input register, held-sequence state, result queue
// datapath: a word is captured in the input register, scanned combinationally there, and its
//   results are written into the result queue, whose head drives the output
// throughput: one input word per cycle while the eight-entry result queue has room for four
//   words; results drain one per cycle while ready is high, over the single queue read port
// reset: synchronous rst empties the input register, the held sequence and the queue
module utf8_lossy_sanitizer_unit (
  input  logic          clk,
  input  logic          rst,
  u8s_byte_if.sink      data,
  u8s_result_if.source  result
);
  import u8s_pkg::*;

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             in_end;
  logic [1:0]       pend_cnt;
  logic [2:0][7:0]  pend_bytes;
  logic             adv;
  logic [OQ_CW-1:0] level;
  scan_t            scan;

  assign adv = in_valid && (level <= OQ_CW'(OQ_DEPTH - MAX_RES));
  assign data.ready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      pend_cnt <= '0;
    end else begin
      if (data.ready) begin
        in_valid <= data.valid;
      end
      if (adv) begin
        pend_cnt <= scan.hold_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (data.valid && data.ready) begin
      in_byte <= data.in_byte;
      in_end <= data.end_of_string;
    end
    if (adv) begin
      pend_bytes <= scan.hold_bytes;
    end
  end

  u8s_scan u_scan (
    .pend_cnt   (pend_cnt),
    .pend_bytes (pend_bytes),
    .in_byte    (in_byte),
    .end_flag   (in_end),
    .scan       (scan)
  );

  u8s_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .push   (adv),
    .scan   (scan),
    .level  (level),
    .result (result)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= OQ_CW'(OQ_DEPTH))
    else $error("result queue over its depth");

  a_flush_at_end: assert property (@(posedge clk) disable iff (rst)
    adv && in_end |=> pend_cnt == 2'd0)
    else $error("bytes still held after end of string");

  a_empty_step_holds: assert property (@(posedge clk) disable iff (rst)
    adv && scan.num == 3'd0 |=> pend_cnt != 2'd0)
    else $error("word gave no result and nothing is held");

endmodule

// ----- test/tb.sv -----
// testbench for the utf-8 lossy sanitizer: random and directed byte streams checked word by word
module tb;
  import u8s_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 125;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct {
    logic [7:0] b;
    bit         eos;
  } raw_byte_t;

  class sanitize_scoreboard;
    logic [7:0]  held [3];
    int unsigned held_cnt;
    int unsigned seq_len;
    res_t        sanitized_q [$];
    int unsigned errors;

    function new();
      held_cnt = 0;
      seq_len  = 0;
      errors   = 0;
    endfunction

    function int unsigned seq_length(logic [7:0] c);
      if (c <= ASCII_MAX) return 1;
      if (c >= LEAD2_MIN && c <= 8'hDF) return 2;
      if (c >= LEAD_E0 && c <= 8'hEF) return 3;
      if (c >= LEAD_F0 && c <= LEAD4_MAX) return 4;
      return 0;
    endfunction

    function bit prefix_good(logic [7:0] s [4], int unsigned at, int unsigned avail,
                             int unsigned len);
      int unsigned j;
      for (j = 1; j < avail; j++) begin
        if ((s[at+j] & MASK_C0) != CONT_TAG) return 0;
      end
      if (avail >= 2) begin
        if (len == 3 && ((s[at] == LEAD_E0 && s[at+1] < CONT_A0) ||
                         (s[at] == LEAD_ED && s[at+1] >= CONT_A0))) return 0;
        if (len == 4 && ((s[at] == LEAD_F0 && s[at+1] < CONT_90) ||
                         (s[at] == LEAD4_MAX && s[at+1] > CONT_8F))) return 0;
      end
      return 1;
    endfunction

    function void accept_byte(logic [7:0] b, bit eos);
      logic [7:0]  seq [4];
      res_t        step_q [$];
      res_t        w;
      int unsigned n, i, j, len, avail;
      n = 0;
      i = 0;
      for (j = 0; j < held_cnt; j++) begin
        seq[n] = held[j];
        n++;
      end
      seq[n] = b;
      n++;
      held_cnt = 0;
      seq_len  = 0;
      while (i < n) begin
        len   = seq_length(seq[i]);
        avail = n - i;
        if (avail > len) avail = len;
        if (len == 0 || !prefix_good(seq, i, avail, len) || (avail < len && eos)) begin
          w.out_byte = SUBST_CHAR;
          w.was_replaced = 1'b1;
          w.run_last = 1'b0;
          step_q = {step_q, w};
          i++;
        end else if (avail == len) begin
          for (j = 0; j < len; j++) begin
            w.out_byte = seq[i+j];
            w.was_replaced = 1'b0;
            w.run_last = 1'b0;
            step_q = {step_q, w};
          end
          i += len;
        end else begin
          // sequence still incomplete: keep what remains
          for (j = 0; j < n - i; j++) held[j] = seq[i+j];
          held_cnt = n - i;
          seq_len  = len;
          i = n;
        end
      end
      for (j = 0; j < step_q.size(); j++) begin
        w = step_q[j];
        w.run_last = (j == step_q.size() - 1);
        sanitized_q = {sanitized_q, w};
      end
    endfunction

    function void check_word(logic [7:0] ob, logic rep, logic last);
      res_t want;
      if (sanitized_q.size() == 0) begin
        $error("unexpected word: out_byte 0x%02h was_replaced %0b run_last %0b", ob, rep, last);
        errors++;
        return;
      end
      want = sanitized_q.pop_front();
      if (ob !== want.out_byte) begin
        $error("out_byte: expected 0x%02h, actual 0x%02h", want.out_byte, ob);
        errors++;
      end
      if (rep !== want.was_replaced) begin
        $error("was_replaced: expected %0b, actual %0b", want.was_replaced, rep);
        errors++;
      end
      if (last !== want.run_last) begin
        $error("run_last: expected %0b, actual %0b", want.run_last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  u8s_byte_if   byte_ch ();
  u8s_result_if word_ch ();

  utf8_lossy_sanitizer_unit dut (
    .clk    (clk),
    .rst    (rst),
    .data   (byte_ch),
    .result (word_ch)
  );

  sanitize_scoreboard sb;
  raw_byte_t          raw_bytes_q [$];
  int unsigned        idle_cycles;
  int unsigned        stall_left = 0;
  int unsigned        stall_mode = 0;
  logic [7:0]         stall_mask = 8'hFF;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void push_byte(logic [7:0] b, bit eos);
    raw_byte_t it;
    it.b   = b;
    it.eos = eos;
    raw_bytes_q = {raw_bytes_q, it};
  endfunction

  function automatic void make_char(int unsigned len, output logic [7:0] c [4]);
    int unsigned j;
    for (j = 0; j < 4; j++) c[j] = CONT_TAG | 8'($urandom_range(0, 63));
    case (len)
      1: c[0] = 8'($urandom_range(0, 127));
      2: c[0] = 8'($urandom_range(LEAD2_MIN, 8'hDF));
      3: begin
        c[0] = 8'($urandom_range(LEAD_E0, 8'hEF));
        if (c[0] == LEAD_E0) c[1] = 8'($urandom_range(CONT_A0, 8'hBF));
        else if (c[0] == LEAD_ED) c[1] = 8'($urandom_range(CONT_TAG, 8'h9F));
      end
      default: begin
        c[0] = 8'($urandom_range(LEAD_F0, LEAD4_MAX));
        if (c[0] == LEAD_F0) c[1] = 8'($urandom_range(CONT_90, 8'hBF));
        else if (c[0] == LEAD4_MAX) c[1] = 8'($urandom_range(CONT_TAG, CONT_8F));
      end
    endcase
  endfunction

  function automatic void build_directed();
    // well-formed at each length, at range edges
    push_byte(8'h7F, 0);
    push_byte(8'hC2, 0); push_byte(8'h80, 0);
    push_byte(8'hED, 0); push_byte(8'h9F, 0); push_byte(8'hBF, 0);
    push_byte(8'hF4, 0); push_byte(8'h8F, 0); push_byte(8'hBF, 0); push_byte(8'hBF, 0);
    // bad leads and a lone continuation
    push_byte(8'hC0, 0); push_byte(8'hF5, 0); push_byte(8'hBF, 0); push_byte(8'hFF, 0);
    // overlong, surrogate, out of range
    push_byte(8'hE0, 0); push_byte(8'h9F, 0);
    push_byte(8'hED, 0); push_byte(8'hA0, 0);
    push_byte(8'hF0, 0); push_byte(8'h8F, 0);
    push_byte(8'hF4, 0); push_byte(8'h90, 0);
    // cut off by end of string, then a plain end
    push_byte(8'hE2, 0); push_byte(8'h82, 1);
    push_byte(8'h00, 1);
  endfunction

  function automatic void build_random();
    logic [7:0]  c [4];
    int unsigned len, kind, j, keep, added;
    bit          eos_last;
    added = 0;
    while (added < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 4);
      make_char(len, c);
      keep = len;
      eos_last = ($urandom_range(0, 7) == 0);
      case (kind)
        6: begin
          c[0] = 8'($urandom);
          keep = 1;
          eos_last = ($urandom_range(0, 3) == 0);
        end
        7: if (len > 1) keep = $urandom_range(1, len - 1);
        8: if (len > 1) c[$urandom_range(1, len - 1)] = 8'($urandom);
        9: begin
          if (len > 1) keep = $urandom_range(1, len - 1);
          eos_last = 1;
        end
        default: ;
      endcase
      for (j = 0; j < keep; j++) begin
        push_byte(c[j], eos_last && (j == keep - 1));
        added++;
      end
    end
    raw_bytes_q[raw_bytes_q.size() - 1].eos = 1;
  endfunction

  task automatic send_bytes();
    int unsigned burst, gap;
    raw_byte_t   it;
    while (raw_bytes_q.size() != 0) begin
      burst = $urandom_range(1, 20);
      while (burst != 0 && raw_bytes_q.size() != 0) begin
        it = raw_bytes_q.pop_front();
        byte_ch.valid <= 1'b1;
        byte_ch.in_byte <= it.b;
        byte_ch.end_of_string <= it.eos;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        byte_ch.valid <= 1'b0;
        byte_ch.in_byte <= 8'($urandom);
        byte_ch.end_of_string <= 1'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    byte_ch.valid <= 1'b0;
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_mask <= 8'($urandom);
      stall_left <= $urandom_range(16, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    if (rst) begin
      word_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: word_ch.ready <= 1'b1;
        1: word_ch.ready <= 1'($urandom);
        2: word_ch.ready <= stall_mask[stall_left[2:0]];
        default: word_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        sb.accept_byte(byte_ch.in_byte, byte_ch.end_of_string);
      end
      if (word_ch.valid && word_ch.ready) begin
        sb.check_word(word_ch.out_byte, word_ch.was_replaced, word_ch.run_last);
      end
      if ((byte_ch.valid && byte_ch.ready) || (word_ch.valid && word_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    rst <= 1'b1;
    byte_ch.valid <= 1'b0;
    byte_ch.in_byte <= 8'h00;
    byte_ch.end_of_string <= 1'b0;
    build_directed();
    build_random();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    send_bytes();
    @(posedge clk);
    while (sb.sanitized_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.sanitized_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
